// File: sv/bfont_pkg.sv
// ---------------------------------------------------------------------------
// bfont_pkg
// Shared types, register indexes and the 5x3 font table of the character
// generator.
// ---------------------------------------------------------------------------
package bfont_pkg;

  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_BITS  = 15;   // 5 rows by 3 columns
  localparam int STEP_W      = 4;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] END_CODE   = 8'(32 + GLYPH_COUNT);

  // Configuration register indexes
  typedef enum logic [7:0] {
    REG_ORIGIN_X   = 8'd0,
    REG_ORIGIN_Y   = 8'd1,
    REG_DOT_SCALE  = 8'd2,
    REG_TEXT_COLOR = 8'd3
  } reg_idx_e;

  // One character handed from the front end to the dot sequencer
  typedef struct packed {
    logic [15:0]           base_x;
    logic [GLYPH_BITS-1:0] glyph;
    logic [11:0]           origin_y;
    logic [4:0]            scale;
  } job_t;

  // Control word of the dot sequencer program
  typedef struct packed {
    logic [STEP_W-1:0] bit_idx;   // glyph bit tested in this step
    logic              row_end;   // last column: move to next row
    logic              prog_end;  // last step of the program
  } ucode_t;

  localparam logic [15:0] GLYPH_ROM [GLYPH_COUNT] = '{
    16'h0000, 16'h2092, 16'h002d, 16'h5f7d, 16'h279e, 16'h52a5, 16'h7ad6, 16'h0012,
    16'h4494, 16'h1491, 16'h017a, 16'h05d0, 16'h1400, 16'h01c0, 16'h0400, 16'h12a4,
    16'h2b6a, 16'h749a, 16'h752a, 16'h38a3, 16'h4f4a, 16'h38cf, 16'h3bce, 16'h12a7,
    16'h3aae, 16'h49ae, 16'h0410, 16'h1410, 16'h4454, 16'h0e38, 16'h1511, 16'h10e3,
    16'h73ee, 16'h5f7a, 16'h3beb, 16'h624e, 16'h3b6b, 16'h73cf, 16'h13cf, 16'h6b4e,
    16'h5bed, 16'h7497, 16'h2b27, 16'h5add, 16'h7249, 16'h5b7d, 16'h5b6b, 16'h3b6e,
    16'h12eb, 16'h4f6b, 16'h5aeb, 16'h388e, 16'h2497, 16'h6b6d, 16'h256d, 16'h5f6d,
    16'h5aad, 16'h24ad, 16'h72a7, 16'h6496, 16'h4889, 16'h3493, 16'h002a, 16'hf000,
    16'h0011, 16'h6b98, 16'h3b79, 16'h7270, 16'h7b74, 16'h6750, 16'h95d6, 16'hb9ee,
    16'h5b59, 16'h6410, 16'hb482, 16'h56e8, 16'h6492, 16'h5be8, 16'h5b58, 16'h3b70,
    16'h976a, 16'hcd6a, 16'h1370, 16'h38f0, 16'h64ba, 16'h3b68, 16'h2568, 16'h5f68,
    16'h54a8, 16'hb9ad, 16'h73b8, 16'h64d6, 16'h2492, 16'h3593, 16'h03e0
  };

  // Blank for control codes, space, DEL and the upper half
  function automatic logic [GLYPH_BITS-1:0] glyph_lookup(input logic [7:0] code);
    logic [7:0]  idx;
    logic [15:0] word;
    idx  = code - FIRST_CODE;
    word = '0;
    if ((code > FIRST_CODE) && (code < END_CODE)) begin
      word = GLYPH_ROM[idx[6:0]];
    end
    return word[GLYPH_BITS-1:0];
  endfunction

endpackage

// File: sv/bfont_seq.sv
// ---------------------------------------------------------------------------
// bfont_seq
// Microcoded dot sequencer: walks the glyph bits of one character in
// row-then-column order and emits one dot request per lit bit.
// ---------------------------------------------------------------------------
module bfont_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bfont_pkg::job_t   job_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       dot_x_o,
  output logic [15:0]       dot_y_o,
  output logic              last_dot_o
);
  import bfont_pkg::*;

  // Program: one step per glyph bit
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw.bit_idx  = step;
    cw.row_end  = 1'b0;
    cw.prog_end = 1'b0;
    unique case (step)
      4'd2, 4'd5, 4'd8, 4'd11: cw.row_end = 1'b1;
      4'd14: begin
        cw.row_end  = 1'b1;
        cw.prog_end = 1'b1;
      end
      4'd15: cw.prog_end = 1'b1;
      default: ;
    endcase
    return cw;
  endfunction

  logic                  busy_q;
  logic [STEP_W-1:0]     step_q;
  logic [GLYPH_BITS-1:0] glyph_q;
  logic [15:0]           base_x_q;
  logic [11:0]           origin_y_q;
  logic [4:0]            scale_q;
  logic [6:0]            col_off_q;
  logic [7:0]            row_off_q;
  logic                  out_valid_q;
  logic [15:0]           dot_x_q;
  logic [15:0]           dot_y_q;
  logic                  last_q;

  ucode_t                cw;
  logic                  lit;
  logic                  out_free;
  logic                  active;
  logic                  advance;
  logic                  emit;
  logic [GLYPH_BITS-1:0] rest;

  always_comb begin
    cw       = ucode(step_q);
    lit      = glyph_q[cw.bit_idx];
    out_free = !out_valid_q || out_ready_i;
    active   = busy_q && (glyph_q != '0);
    advance  = active && (!lit || out_free);
    emit     = active && lit && out_free;
    rest     = glyph_q & ~(GLYPH_BITS'(1) << cw.bit_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q && (glyph_q == '0)) begin
        // no lit bits left: jump out of the program
        busy_q <= 1'b0;
        step_q <= '0;
      end else if (advance) begin
        if (cw.prog_end) begin
          busy_q <= 1'b0;
          step_q <= '0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      glyph_q    <= job_i.glyph;
      base_x_q   <= job_i.base_x;
      origin_y_q <= job_i.origin_y;
      scale_q    <= job_i.scale;
      col_off_q  <= '0;
      row_off_q  <= '0;
    end else if (advance) begin
      if (emit) begin
        glyph_q <= rest;
      end
      if (cw.row_end) begin
        col_off_q <= '0;
        row_off_q <= row_off_q + {3'b000, scale_q};
      end else begin
        col_off_q <= col_off_q + {2'b00, scale_q};
      end
    end
    if (emit) begin
      dot_x_q <= base_x_q + {9'd0, col_off_q};
      dot_y_q <= {4'd0, origin_y_q} + {8'd0, row_off_q};
      last_q  <= (rest == '0);
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign dot_x_o     = dot_x_q;
  assign dot_y_o     = dot_y_q;
  assign last_dot_o  = last_q;

`ifndef SYNTHESIS
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("character started while sequencer busy");

  a_step_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (step_q == '0))
    else $error("step counter not home while idle");

  a_emit_lit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (glyph_q[cw.bit_idx] && (step_q != 4'd15)))
    else $error("dot emitted for unlit glyph bit");

  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (rest == '0)) |=> (glyph_q == '0))
    else $error("glyph bits remain after last dot");
`endif

endmodule

// File: sv/bitmap_font_text_dot_generator.sv
// ---------------------------------------------------------------------------
// bitmap_font_text_dot_generator
// 5x3 bitmap-font character generator: turns character bytes into square
// dot requests placed at the text cursor.
// ---------------------------------------------------------------------------
// Timing: the first dot request is registered once the program has stepped
//   through the glyph bits of the accepted character up to its first lit bit.
// A new character is accepted only when the sequencer is idle again, which it
//   is once no lit glyph bits are left or the program has ended. Output stalls
//   hold the sequencer up.
// Reset: origin 0, dot scale 1, cursor 0, no request pending.
module bitmap_font_text_dot_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        string_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] dot_x_o,
  output logic [15:0] dot_y_o,
  output logic        last_dot_o
);
  import bfont_pkg::*;

  logic [11:0] origin_x_q;
  logic [11:0] origin_y_q;
  logic [4:0]  scale_q;
  logic [15:0] cursor_q;
  logic        busy;
  logic        accept;
  logic [15:0] cur_base;
  job_t        job;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy;
  assign accept      = in_valid_i && in_ready_o;
  assign cur_base    = string_start_i ? {4'd0, origin_x_q} : cursor_q;

  always_comb begin
    job.base_x   = cur_base;
    job.glyph    = glyph_lookup(char_code_i);
    job.origin_y = origin_y_q;
    job.scale    = scale_q;
  end

  // Text color is only meaningful to the downstream writer; drop it here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      scale_q    <= 5'd1;
      cursor_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_ORIGIN_X:  origin_x_q <= cfg_data_i[11:0];
          REG_ORIGIN_Y:  origin_y_q <= cfg_data_i[11:0];
          REG_DOT_SCALE: scale_q    <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (accept) begin
        // advance by four dots, blank or not
        cursor_q <= cur_base + {9'd0, scale_q, 2'b00};
      end
    end
  end

  bfont_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .job_i       (job),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dot_x_o     (dot_x_o),
    .dot_y_o     (dot_y_o),
    .last_dot_o  (last_dot_o)
  );

endmodule

// File: verif/bitmap_font_text_dot_generator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bitmap_font_text_dot_generator_test
// Feeds character bytes through the 5x3 character generator under bursty
// input and a stalling output, and checks every dot request against a
// scoreboard filled by a behavioral glyph tracer or, for typed rows, by hand.
// ---------------------------------------------------------------------------
module bitmap_font_text_dot_generator_test;
  import bfont_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int REG_COUNT = 4;
  localparam int SPACE_CODE = 32;
  localparam int DEL_CODE = 127;

  localparam logic [15:0] FONT_5X3 [95] = '{
    16'h0000, 16'h2092, 16'h002d, 16'h5f7d, 16'h279e, 16'h52a5, 16'h7ad6, 16'h0012,
    16'h4494, 16'h1491, 16'h017a, 16'h05d0, 16'h1400, 16'h01c0, 16'h0400, 16'h12a4,
    16'h2b6a, 16'h749a, 16'h752a, 16'h38a3, 16'h4f4a, 16'h38cf, 16'h3bce, 16'h12a7,
    16'h3aae, 16'h49ae, 16'h0410, 16'h1410, 16'h4454, 16'h0e38, 16'h1511, 16'h10e3,
    16'h73ee, 16'h5f7a, 16'h3beb, 16'h624e, 16'h3b6b, 16'h73cf, 16'h13cf, 16'h6b4e,
    16'h5bed, 16'h7497, 16'h2b27, 16'h5add, 16'h7249, 16'h5b7d, 16'h5b6b, 16'h3b6e,
    16'h12eb, 16'h4f6b, 16'h5aeb, 16'h388e, 16'h2497, 16'h6b6d, 16'h256d, 16'h5f6d,
    16'h5aad, 16'h24ad, 16'h72a7, 16'h6496, 16'h4889, 16'h3493, 16'h002a, 16'hf000,
    16'h0011, 16'h6b98, 16'h3b79, 16'h7270, 16'h7b74, 16'h6750, 16'h95d6, 16'hb9ee,
    16'h5b59, 16'h6410, 16'hb482, 16'h56e8, 16'h6492, 16'h5be8, 16'h5b58, 16'h3b70,
    16'h976a, 16'hcd6a, 16'h1370, 16'h38f0, 16'h64ba, 16'h3b68, 16'h2568, 16'h5f68,
    16'h54a8, 16'hb9ad, 16'h73b8, 16'h64d6, 16'h2492, 16'h3593, 16'h03e0
  };

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } dot_t;

  // One character request; typed rows carry their dots written out by hand
  typedef struct packed {
    logic [7:0]       code;
    logic             start;
    logic             typed;
    logic [2:0]       n_dots;
    logic [3:0][15:0] xs;
    logic [3:0][15:0] ys;
  } char_row_t;

  // Starts from reset: origin 0, scale 1, cursor 0
  char_row_t char_table [21] = '{
    '{8'h00, 1'b1, 1'b1, 3'd0, '0, '0},
    '{8'h20, 1'b0, 1'b1, 3'd0, '0, '0},
    '{8'h21, 1'b0, 1'b1, 3'd4, {16'd9, 16'd9, 16'd9, 16'd9},
      {16'd4, 16'd2, 16'd1, 16'd0}},
    '{8'h7f, 1'b0, 1'b1, 3'd0, '0, '0},
    '{8'hff, 1'b0, 1'b1, 3'd0, '0, '0},
    '{8'h80, 1'b0, 1'b1, 3'd0, '0, '0},
    '{8'h2e, 1'b0, 1'b1, 3'd1, {48'd0, 16'd25}, {48'd0, 16'd3}},
    '{8'h2e, 1'b1, 1'b1, 3'd1, {48'd0, 16'd1}, {48'd0, 16'd3}},
    '{8'h22, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h7e, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h40, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h23, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h5f, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h66, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h67, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h1f, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h41, 1'b1, 1'b0, 3'd0, '0, '0},
    '{8'h57, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h7d, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'h30, 1'b0, 1'b0, 3'd0, '0, '0},
    '{8'haa, 1'b0, 1'b0, 3'd0, '0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  char_code = '0;
  logic        string_start = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] dot_x_o;
  logic [15:0] dot_y_o;
  logic        last_dot_o;

  // Tracer copy of the block state
  logic [11:0] org_x = '0;
  logic [11:0] org_y = '0;
  logic [4:0]  scale = 5'd1;
  logic [31:0] color = '0;
  logic [15:0] cur_x = '0;

  dot_t glyph_dots[$];
  dot_t dots_due[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   burst_left = 0;
  int   pace_left = 0;
  logic [7:0] pace_pat = 8'hff;

  bitmap_font_text_dot_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code),
    .string_start_i (string_start),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .dot_x_o        (dot_x_o),
    .dot_y_o        (dot_y_o),
    .last_dot_o     (last_dot_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Lay out the lit dots of one character and advance the cursor
  function automatic void trace_glyph(input logic [7:0] code, input logic start);
    logic [15:0] bits;
    dot_t        d;
    bits = '0;
    glyph_dots.delete();
    if (start) begin
      cur_x = 16'(org_x);
    end
    if ((int'(code) > SPACE_CODE) && (int'(code) < DEL_CODE)) begin
      bits = FONT_5X3[int'(code) - SPACE_CODE];
    end
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (bits[r * 3 + c]) begin
          d.x = cur_x + 16'(c * int'(scale));
          d.y = 16'(org_y) + 16'(r * int'(scale));
          d.last = 1'b0;
          glyph_dots.push_back(d);
        end
      end
    end
    if (glyph_dots.size() > 0) begin
      glyph_dots[glyph_dots.size() - 1].last = 1'b1;
    end
    cur_x = cur_x + 16'(4 * int'(scale));
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 8'($urandom_range(0, SPACE_CODE));
      1: return 8'($urandom_range(DEL_CODE, 255));
      default: return 8'($urandom_range(SPACE_CODE + 1, DEL_CODE - 1));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input char_row_t row);
    dot_t d;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    char_code    <= row.code;
    string_start <= row.start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    trace_glyph(row.code, row.start);
    if (row.typed) begin
      for (int k = 0; k < int'(row.n_dots); k++) begin
        d.x = row.xs[k];
        d.y = row.ys[k];
        d.last = (k == int'(row.n_dots) - 1);
        dots_due.push_back(d);
      end
    end else begin
      foreach (glyph_dots[k]) dots_due.push_back(glyph_dots[k]);
    end
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_random(input int count, input bit blanks_only);
    char_row_t row;
    for (int i = 0; i < count; i++) begin
      row = '0;
      row.code = blanks_only ? 8'($urandom_range(0, SPACE_CODE)) : pick_code();
      row.start = !blanks_only && ($urandom_range(0, 7) == 0);
      send_char(row);
    end
  endtask

  // Hold valid across a batch of writes; the caller lowers it
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ORIGIN_X:   org_x = data[11:0];
      REG_ORIGIN_Y:   org_y = data[11:0];
      REG_DOT_SCALE:  scale = data[4:0];
      REG_TEXT_COLOR: color = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic setup(input logic [11:0] ox, input logic [11:0] oy,
                       input logic [4:0] sc, input logic [31:0] col);
    write_reg(REG_ORIGIN_X, {20'($urandom), ox});
    write_reg(REG_ORIGIN_Y, {20'($urandom), oy});
    write_reg(REG_DOT_SCALE, {27'($urandom), sc});
    write_reg(REG_TEXT_COLOR, col);
    write_reg(8'($urandom_range(REG_COUNT, 255)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Wait out every pending dot, then the tail of a blank character
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (dots_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver stall pattern, reloaded now and then
  always @(negedge clk_i) begin
    if (pace_left == 0) begin
      pace_left = $urandom_range(20, 80);
      pace_pat = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      if (pace_pat == 8'h00) begin
        pace_pat = 8'h81;
      end
    end
    pace_left--;
    pace_pat = {pace_pat[6:0], pace_pat[7]};
    out_ready <= pace_pat[0];
  end

  always @(posedge clk_i) begin : check_dots
    dot_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (dots_due.size() == 0) begin
        $display("%0t: unexpected dot x=%0d y=%0d last=%0b", $time, dot_x_o, dot_y_o,
                 last_dot_o);
        mismatches++;
      end else begin
        want = dots_due.pop_front();
        if (dot_x_o !== want.x) begin
          $display("%0t: dot_x expected %0d got %0d", $time, want.x, dot_x_o);
          mismatches++;
        end
        if (dot_y_o !== want.y) begin
          $display("%0t: dot_y expected %0d got %0d", $time, want.y, dot_y_o);
          mismatches++;
        end
        if (last_dot_o !== want.last) begin
          $display("%0t: last_dot expected %0b got %0b", $time, want.last, last_dot_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    foreach (char_table[i]) send_char(char_table[i]);
    drain();

    setup(12'hfff, 12'hfff, 5'd16, 32'hffff_ffff);
    send_random(16, 1'b0);
    drain();
    setup(12'h000, 12'h000, 5'd1, 32'h0000_0000);
    send_random(16, 1'b0);
    drain();
    // zero scale stacks each character's dots on one point and stops the cursor advancing
    setup(12'($urandom), 12'($urandom), 5'd0, $urandom);
    send_random(16, 1'b0);
    drain();
    setup(12'($urandom), 12'($urandom), 5'd31, $urandom);
    send_random(16, 1'b0);
    drain();
    setup(12'($urandom), 12'($urandom), 5'($urandom_range(1, 16)), $urandom);
    send_random(16, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bfont_pkg.sv
sv/bfont_seq.sv
sv/bitmap_font_text_dot_generator.sv
verif/bitmap_font_text_dot_generator_test.sv
